// ===== hdl/pvt_pkg.sv =====
// Shared types and constants for the polygon vertex table with snap search.
package pvt_pkg;

	localparam int MAX_BLOCKS_DEF = 256;
	localparam int MAX_VERTS_DEF  = 8;

	typedef enum logic [2:0] {
		OP_APPEND     = 3'd0,
		OP_DELETE     = 3'd1,
		OP_CLEAR      = 3'd2,
		OP_SNAP_PLAN  = 3'd3,
		OP_SNAP_PROJ  = 3'd4,
		OP_SNAP_BLOCK = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MISS      = 2'd1,
		ST_REJECT    = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic run;
		logic emit;
	} pvt_cmd_t;

	typedef struct packed {
		logic need_copy;
		logic need_shift;
		logic need_scan;
		logic hit;
		logic drained;
		logic out_busy;
	} pvt_stat_t;

endpackage

// ===== hdl/polygon_vertex_table_snap_search.sv =====
// Top level of the polygon vertex table with snap search.
// A result passes through the execute state and is registered for output; a committing append copies
// the pending polygon into a new block, and a delete moves every block above the target down by one.
// A snap search reads one slot per cycle: a hit ends the sweep at the first matching slot, a miss
// ends it once every slot is swept; the next transaction is accepted once the previous result is presented.
// Reset clears the block count and pending polygon at once; the memories need no clearing pass.
module polygon_vertex_table_snap_search
	import pvt_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int MAX_VERTS  = MAX_VERTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic signed [23:0] coord_x,
	input  logic signed [23:0] coord_y,
	input  logic signed [23:0] coord_z,
	input  logic               closes_polygon,
	input  logic [7:0]         target_block,
	input  logic [23:0]        snap_window,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [8:0]  found_block,
	output logic [2:0]         vertex_index,
	output logic signed [23:0] snap_x,
	output logic signed [24:0] snap_y
);

	pvt_cmd_t  cmd;
	pvt_stat_t stat;

	pvt_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pvt_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_VERTS  (MAX_VERTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.coord_z        (coord_z),
		.closes_polygon (closes_polygon),
		.target_block   (target_block),
		.snap_window    (snap_window),
		.status         (status),
		.found_block    (found_block),
		.vertex_index   (vertex_index),
		.snap_x         (snap_x),
		.snap_y         (snap_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

// ===== hdl/pvt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/pvt_ctl.sv =====
// Controller state machine that sequences execute, sweep and response phases.
module pvt_ctl
	import pvt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pvt_stat_t stat,
	output pvt_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_COPY  = 6'b000100,
		S_SHIFT = 6'b001000,
		S_SCAN  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.need_copy) begin
					state_d = S_COPY;
				end else if (stat.need_shift) begin
					state_d = S_SHIFT;
				end else if (stat.need_scan) begin
					state_d = S_SCAN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_COPY, S_SHIFT: begin
				if (stat.drained) begin
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (stat.hit || stat.drained) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!stat.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = (state_q == S_IDLE) && in_valid;
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.run  = (state_q == S_COPY) || (state_q == S_SHIFT) || (state_q == S_SCAN);
	assign cmd.emit = (state_q == S_RESP) && !stat.out_busy;

endmodule

// ===== hdl/pvt_dp.sv =====
// Datapath with table state, vertex memories, sweep pipeline and result registers.
module pvt_dp
	import pvt_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
	parameter int MAX_VERTS  = MAX_VERTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         operation,
	input  logic signed [23:0] coord_x,
	input  logic signed [23:0] coord_y,
	input  logic signed [23:0] coord_z,
	input  logic               closes_polygon,
	input  logic [7:0]         target_block,
	input  logic [23:0]        snap_window,
	output logic [1:0]         status,
	output logic signed [8:0]  found_block,
	output logic [2:0]         vertex_index,
	output logic signed [23:0] snap_x,
	output logic signed [24:0] snap_y,
	output logic               out_valid,
	input  logic               out_ready,
	input  pvt_cmd_t           cmd,
	output pvt_stat_t          stat
);

	localparam int BW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW     = $clog2(MAX_BLOCKS + 1);
	localparam int VW     = $clog2(MAX_VERTS);
	localparam int PW     = $clog2(MAX_VERTS + 1);
	localparam int SW     = PW + 1;
	localparam int AW     = BW + VW;
	localparam int TW     = ((CW > 8) ? CW : 8) + 1;
	localparam int VDEPTH = 2 ** AW;
	localparam int PDEPTH = 2 ** VW;
	localparam int BDEPTH = 2 ** BW;

	localparam logic [CW-1:0] MB_C      = CW'(MAX_BLOCKS);
	localparam logic [PW-1:0] MV_C      = PW'(MAX_VERTS);
	localparam logic [VW-1:0] LAST_SLOT = VW'(MAX_VERTS - 1);

	op_t                op_q;
	logic signed [23:0] qx_q;
	logic signed [23:0] qy_q;
	logic signed [23:0] qz_q;
	logic               last_q;
	logic [7:0]         tgt_q;
	logic [23:0]        win_q;

	logic [CW-1:0] count_q;
	logic [PW-1:0] pend_cnt_q;
	logic          ovf_q;

	logic [CW-1:0] blk_p_q;
	logic [CW-1:0] end_q;
	logic [VW-1:0] slot_p_q;

	logic          v_s1, v_s2, v_s3;
	logic [CW-1:0] blk_s1, blk_s2, blk_s3;
	logic [VW-1:0] slot_s1, slot_s2, slot_s3;
	logic signed [24:0] tx_s2, ty_s2, tx_s3, ty_s3;
	logic          ok_s2;
	logic          match_s3;

	status_t            res_st_q;
	logic [8:0]         res_fb_q;
	logic [2:0]         res_vi_q;
	logic signed [23:0] res_x_q;
	logic signed [24:0] res_y_q;

	status_t            out_st_q;
	logic [8:0]         out_fb_q;
	logic [2:0]         out_vi_q;
	logic signed [23:0] out_x_q;
	logic signed [24:0] out_y_q;
	logic               out_valid_q;

	logic [TW-1:0] tgt_w;
	logic          tgt_ok;
	logic          full;
	logic          pend_full;
	logic          need_copy;
	logic          need_shift;
	logic          need_scan;
	logic          is_scan;
	logic          issue_done;
	logic [CW-1:0] tgt_c;
	logic [CW-1:0] tgt_c1;

	logic          v_we;
	logic [AW-1:0] v_waddr;
	logic [71:0]   v_wdata;
	logic [AW-1:0] v_raddr;
	logic [71:0]   v_rdata;
	logic          b_we;
	logic [BW-1:0] b_waddr;
	logic [PW-1:0] b_wdata;
	logic [PW-1:0] b_rdata;
	logic          p_we;
	logic [71:0]   p_rdata;
	logic [CW-1:0] wb;

	logic signed [24:0] rx_e, ry_e, rz_e;
	logic signed [25:0] dx, dy, winp, winn;

	status_t            r_st;
	logic [8:0]         r_fb;
	logic [2:0]         r_vi;

	assign tgt_w      = TW'(tgt_q);
	assign tgt_ok     = tgt_w < TW'(count_q);
	assign full       = count_q >= MB_C;
	assign pend_full  = pend_cnt_q >= MV_C;
	assign need_copy  = (op_q == OP_APPEND) && last_q && !ovf_q && !pend_full && !full;
	assign need_shift = (op_q == OP_DELETE) && tgt_ok;
	assign is_scan    = (op_q == OP_SNAP_PLAN) || (op_q == OP_SNAP_PROJ) ||
		(op_q == OP_SNAP_BLOCK);
	assign need_scan  = (op_q == OP_SNAP_PLAN) || (op_q == OP_SNAP_PROJ) ||
		((op_q == OP_SNAP_BLOCK) && tgt_ok);
	assign tgt_c      = CW'(tgt_q);
	assign tgt_c1     = CW'(tgt_w + TW'(1));
	assign issue_done = blk_p_q >= end_q;

	assign v_raddr = {blk_p_q[BW-1:0], slot_p_q};
	assign wb      = (op_q == OP_DELETE) ? (blk_s1 - CW'(1)) : blk_s1;
	assign v_we    = cmd.run && v_s1 && ((op_q == OP_APPEND) || (op_q == OP_DELETE));
	assign v_waddr = {wb[BW-1:0], slot_s1};
	assign v_wdata = (op_q == OP_DELETE) ? v_rdata : p_rdata;
	assign p_we    = cmd.exec && (op_q == OP_APPEND) && !pend_full;

	always_comb begin
		b_we    = 1'b0;
		b_waddr = count_q[BW-1:0];
		b_wdata = pend_cnt_q + PW'(1);
		if (cmd.exec && need_copy) begin
			b_we = 1'b1;
		end else if (cmd.run && v_s1 && (op_q == OP_DELETE) && (slot_s1 == '0)) begin
			b_we    = 1'b1;
			b_waddr = wb[BW-1:0];
			b_wdata = b_rdata;
		end
	end

	pvt_ram #(.WIDTH(72), .DEPTH(VDEPTH)) u_vert_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	pvt_ram #(.WIDTH(PW), .DEPTH(BDEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (blk_p_q[BW-1:0]),
		.rdata (b_rdata)
	);

	pvt_ram #(.WIDTH(72), .DEPTH(PDEPTH)) u_pend_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (pend_cnt_q[VW-1:0]),
		.wdata ({qx_q, qy_q, qz_q}),
		.raddr (slot_p_q),
		.rdata (p_rdata)
	);

	assign rx_e = 25'($signed(v_rdata[71:48]));
	assign ry_e = 25'($signed(v_rdata[47:24]));
	assign rz_e = 25'($signed(v_rdata[23:0]));
	assign winp = $signed({2'b00, win_q});
	assign winn = -winp;
	assign dx   = 26'(tx_s2) - 26'(qx_q);
	assign dy   = 26'(ty_s2) - 26'(qy_q);

	always_comb begin
		r_st = ST_BAD_INDEX;
		r_fb = '1;
		r_vi = '0;
		case (op_q)
			OP_APPEND: begin
				if (!last_q) begin
					if (pend_full) begin
						r_st = ST_REJECT;
					end else begin
						r_st = ST_OK;
						r_vi = 3'(pend_cnt_q);
					end
				end else if (need_copy) begin
					r_st = ST_OK;
					r_fb = 9'(count_q);
					r_vi = 3'(pend_cnt_q);
				end else begin
					r_st = ST_REJECT;
				end
			end
			OP_DELETE: begin
				if (tgt_ok) begin
					r_st = ST_OK;
					r_fb = 9'(tgt_q);
				end
			end
			OP_CLEAR: r_st = ST_OK;
			OP_SNAP_PLAN, OP_SNAP_PROJ: r_st = ST_MISS;
			OP_SNAP_BLOCK: begin
				if (tgt_ok) begin
					r_st = ST_MISS;
				end
			end
			default: r_st = ST_BAD_INDEX;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(operation);
			qx_q   <= coord_x;
			qy_q   <= coord_y;
			qz_q   <= coord_z;
			last_q <= closes_polygon;
			tgt_q  <= target_block;
			win_q  <= snap_window;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pend_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.exec) begin
			case (op_q)
				OP_APPEND: begin
					if (last_q) begin
						pend_cnt_q <= '0;
						ovf_q      <= 1'b0;
						if (need_copy) begin
							count_q <= count_q + CW'(1);
						end
					end else if (pend_full) begin
						ovf_q <= 1'b1;
					end else begin
						pend_cnt_q <= pend_cnt_q + PW'(1);
					end
				end
				OP_DELETE: begin
					if (tgt_ok) begin
						count_q <= count_q - CW'(1);
					end
				end
				OP_CLEAR: begin
					count_q    <= '0;
					pend_cnt_q <= '0;
					ovf_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_p_q  <= '0;
			end_q    <= '0;
			slot_p_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else if (cmd.exec) begin
			slot_p_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			case (op_q)
				OP_APPEND: begin
					blk_p_q <= count_q;
					end_q   <= count_q + CW'(1);
				end
				OP_DELETE: begin
					blk_p_q <= tgt_c1;
					end_q   <= count_q;
				end
				OP_SNAP_BLOCK: begin
					blk_p_q <= tgt_c;
					end_q   <= tgt_c1;
				end
				default: begin
					blk_p_q <= '0;
					end_q   <= count_q;
				end
			endcase
		end else if (cmd.run) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (!issue_done) begin
				v_s1 <= 1'b1;
				if (slot_p_q == LAST_SLOT) begin
					slot_p_q <= '0;
					blk_p_q  <= blk_p_q + CW'(1);
				end else begin
					slot_p_q <= slot_p_q + VW'(1);
				end
			end else begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run) begin
			blk_s1   <= blk_p_q;
			slot_s1  <= slot_p_q;
			blk_s2   <= blk_s1;
			slot_s2  <= slot_s1;
			tx_s2    <= rx_e;
			ty_s2    <= (op_q == OP_SNAP_PROJ) ? (ry_e - rz_e) : ry_e;
			ok_s2    <= SW'(slot_s1) < SW'(b_rdata);
			blk_s3   <= blk_s2;
			slot_s3  <= slot_s2;
			tx_s3    <= tx_s2;
			ty_s3    <= ty_s2;
			match_s3 <= ok_s2 && (dx < winp) && (dx > winn) && (dy < winp) && (dy > winn);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_st_q <= r_st;
			res_fb_q <= r_fb;
			res_vi_q <= r_vi;
			res_x_q  <= qx_q;
			res_y_q  <= 25'(qy_q);
		end else if (cmd.run && is_scan && v_s3 && match_s3) begin
			res_st_q <= ST_OK;
			res_fb_q <= 9'(blk_s3);
			res_vi_q <= 3'(slot_s3);
			res_x_q  <= tx_s3[23:0];
			res_y_q  <= ty_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_st_q <= res_st_q;
			out_fb_q <= res_fb_q;
			out_vi_q <= res_vi_q;
			out_x_q  <= res_x_q;
			out_y_q  <= res_y_q;
		end
	end

	assign status       = out_st_q;
	assign found_block  = $signed(out_fb_q);
	assign vertex_index = out_vi_q;
	assign snap_x       = out_x_q;
	assign snap_y       = out_y_q;
	assign out_valid    = out_valid_q;

	assign stat.need_copy  = need_copy;
	assign stat.need_shift = need_shift;
	assign stat.need_scan  = need_scan;
	assign stat.hit        = is_scan && v_s3 && match_s3;
	assign stat.drained    = issue_done && !v_s1 && !v_s2 && !v_s3;
	assign stat.out_busy   = out_valid_q && !out_ready;

endmodule

// ===== hdl/pvt_chk.sv =====
// Port-level checker for the polygon vertex table, bound to the top level.
module pvt_chk
	import pvt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic signed [8:0] found_block,
	input logic [2:0]        vertex_index
);

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in work");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_MISS)) |-> ((found_block == 9'h1FF) && (vertex_index == 3'd0)))
		else $error("miss result carries a block or vertex");

	a_bad_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_BAD_INDEX)) |-> (found_block == 9'h1FF))
		else $error("bad index result carries a block");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(found_block)))
		else $error("stalled result changed");

endmodule

bind polygon_vertex_table_snap_search pvt_chk u_chk (.*);
